### sv/mwm_pkg.sv
// mwm_pkg: widths, register indexes and pipeline payload types of the
// mecanum wheel mixer. No dependencies.
package mwm_pkg;

    localparam int unsigned IN_W    = 16;
    localparam int unsigned WK_W    = 33;
    localparam int unsigned SUM_W   = 34;
    localparam int unsigned MAG_W   = 33;
    localparam int unsigned PWM_W   = 10;
    localparam int unsigned OUT_W   = 11;
    localparam int unsigned NUM_W   = MAG_W + PWM_W;
    localparam int unsigned QUO_W   = PWM_W;
    localparam int unsigned LANES   = 4;
    localparam int unsigned REF_W   = 15;
    localparam int unsigned LEVER_W = 16;
    localparam int unsigned REFQ_W  = REF_W + 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LEVER_ARM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM   = 2'd2;

    localparam logic [LEVER_W-1:0] RST_LEVER_ARM = 16'd13107;
    localparam logic [REF_W-1:0]   RST_REF_SPEED = 15'd7680;
    localparam logic [PWM_W-1:0]   RST_MAX_PWM   = 10'd999;

    typedef struct packed {
        logic [LEVER_W-1:0] lever_arm;
        logic [REF_W-1:0]   ref_speed;
        logic [PWM_W-1:0]   max_pwm;
    } t_cfg;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_lane;

    typedef struct packed {
        t_lane [LANES-1:0] lane;
        logic [NUM_W-1:0]  dsh;
        logic              reduced;
    } t_div_item;

endpackage

### sv/mwm_mix.sv
// mwm_mix: four pipeline stages that form the wheel terms, their magnitudes,
// the scaled numerators and the common divisor. Depends on mwm_pkg.
module mwm_mix (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mwm_pkg::t_cfg                      i_cfg,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [mwm_pkg::IN_W-1:0]    i_vel_x,
    input  logic signed [mwm_pkg::IN_W-1:0]    i_vel_y,
    input  logic signed [mwm_pkg::IN_W-1:0]    i_yaw_rate,
    output logic                               o_valid,
    input  logic                               i_ready,
    output mwm_pkg::t_div_item                 o_item
);

    logic                                r_a_v, r_b_v, r_c_v, r_d_v;
    logic                                rdy_a, rdy_b, rdy_c, rdy_d;

    logic signed [mwm_pkg::IN_W-1:0]     r_a_vx, r_a_vy;
    logic signed [mwm_pkg::WK_W-1:0]     r_a_wk;
    logic signed [mwm_pkg::WK_W-1:0]     n_a_wk;

    logic [mwm_pkg::MAG_W-1:0]           r_b_mag [mwm_pkg::LANES];
    logic [mwm_pkg::LANES-1:0]           r_b_neg;
    logic [mwm_pkg::MAG_W-1:0]           n_b_mag [mwm_pkg::LANES];
    logic [mwm_pkg::LANES-1:0]           n_b_neg;
    logic signed [mwm_pkg::SUM_W-1:0]    ext_x, ext_y, ext_w;
    logic signed [mwm_pkg::SUM_W-1:0]    sum [mwm_pkg::LANES];
    logic signed [mwm_pkg::SUM_W-1:0]    neg_sum [mwm_pkg::LANES];

    logic [mwm_pkg::NUM_W-1:0]           r_c_num [mwm_pkg::LANES];
    logic [mwm_pkg::MAG_W-1:0]           r_c_peak;
    logic [mwm_pkg::LANES-1:0]           r_c_neg;
    logic [mwm_pkg::MAG_W-1:0]           pk01, pk23, n_c_peak;

    mwm_pkg::t_div_item                  r_d_item, n_d_item;
    logic [mwm_pkg::MAG_W-1:0]           refq, den;
    logic                                red;

    assign rdy_d   = !r_d_v || i_ready;
    assign rdy_c   = !r_c_v || rdy_d;
    assign rdy_b   = !r_b_v || rdy_c;
    assign rdy_a   = !r_a_v || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_d_v;
    assign o_item  = r_d_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (rdy_a) r_a_v <= i_valid;
            if (rdy_b) r_b_v <= r_a_v;
            if (rdy_c) r_c_v <= r_b_v;
            if (rdy_d) r_d_v <= r_c_v;
        end
    end

    // stage a: yaw term
    assign n_a_wk = mwm_pkg::WK_W'(i_yaw_rate)
                  * $signed({{(mwm_pkg::WK_W-mwm_pkg::LEVER_W){1'b0}}, i_cfg.lever_arm});

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a_vx <= i_vel_x;
            r_a_vy <= i_vel_y;
            r_a_wk <= n_a_wk;
        end
    end

    // stage b: wheel terms and magnitudes
    always_comb begin
        ext_x = mwm_pkg::SUM_W'($signed({r_a_vx, 16'b0}));
        ext_y = mwm_pkg::SUM_W'($signed({r_a_vy, 16'b0}));
        ext_w = mwm_pkg::SUM_W'(r_a_wk);
        sum[0] = ext_y + ext_x + ext_w;
        sum[1] = ext_y - ext_x - ext_w;
        sum[2] = ext_y + ext_x - ext_w;
        sum[3] = ext_y - ext_x + ext_w;
        for (int i = 0; i < mwm_pkg::LANES; i++) begin
            neg_sum[i] = -sum[i];
            n_b_neg[i] = sum[i][mwm_pkg::SUM_W-1];
            n_b_mag[i] = n_b_neg[i] ? neg_sum[i][mwm_pkg::MAG_W-1:0]
                                    : sum[i][mwm_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_a_v) begin
            r_b_mag <= n_b_mag;
            r_b_neg <= n_b_neg;
        end
    end

    // stage c: peak and numerators
    always_comb begin
        pk01     = (r_b_mag[0] > r_b_mag[1]) ? r_b_mag[0] : r_b_mag[1];
        pk23     = (r_b_mag[2] > r_b_mag[3]) ? r_b_mag[2] : r_b_mag[3];
        n_c_peak = (pk01 > pk23) ? pk01 : pk23;
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c && r_b_v) begin
            for (int i = 0; i < mwm_pkg::LANES; i++) begin
                r_c_num[i] <= mwm_pkg::NUM_W'(r_b_mag[i]) * mwm_pkg::NUM_W'(i_cfg.max_pwm);
            end
            r_c_peak <= n_c_peak;
            r_c_neg  <= r_b_neg;
        end
    end

    // stage d: divisor, aligned to the top quotient bit
    always_comb begin
        refq = mwm_pkg::MAG_W'({i_cfg.ref_speed, 16'b0});
        red  = r_c_peak > refq;
        den  = red ? r_c_peak : refq;
        for (int i = 0; i < mwm_pkg::LANES; i++) begin
            n_d_item.lane[i].neg = r_c_neg[i];
            n_d_item.lane[i].rem = r_c_num[i];
            n_d_item.lane[i].quo = '0;
        end
        n_d_item.reduced = red;
        // zero divisor: force every compare to fail so each quotient is zero
        n_d_item.dsh = (den == '0) ? {mwm_pkg::NUM_W{1'b1}}
                     : mwm_pkg::NUM_W'({den, {(mwm_pkg::QUO_W-1){1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (rdy_d && r_c_v) begin
            r_d_item <= n_d_item;
        end
    end

endmodule

### sv/mwm_div_step.sv
// mwm_div_step: one restoring division stage, one quotient bit for each of
// the four wheel lanes. Depends on mwm_pkg.
module mwm_div_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mwm_pkg::t_div_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output mwm_pkg::t_div_item o_item
);

    logic               r_v;
    logic               rdy;
    mwm_pkg::t_div_item r_item, n_item;
    logic               ge;

    assign rdy     = !r_v || i_ready;
    assign o_ready = rdy;
    assign o_valid = r_v;
    assign o_item  = r_item;

    always_comb begin
        n_item = i_item;
        ge     = 1'b0;
        for (int i = 0; i < mwm_pkg::LANES; i++) begin
            ge = i_item.lane[i].rem >= i_item.dsh;
            n_item.lane[i].rem = ge ? i_item.lane[i].rem - i_item.dsh : i_item.lane[i].rem;
            n_item.lane[i].quo = {i_item.lane[i].quo[mwm_pkg::QUO_W-2:0], ge};
        end
        n_item.dsh = i_item.dsh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

### sv/mecanum_wheel_mixer_top.sv
// mecanum_wheel_mixer_top: configuration registers, mixing stages, division
// pipeline and output register. Depends on mwm_pkg, mwm_mix, mwm_div_step.
//
// Takes one velocity command per cycle unless the output side stalls, and
// gives one transfer of four wheel PWM values per command. Four stages form
// the wheel terms, peak and divisor; ten stages each produce one quotient bit
// for all four wheels; one stage clamps to the maximum PWM and applies the
// sign. Write configuration only while no command is in flight.
module mecanum_wheel_mixer_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [mwm_pkg::IN_W-1:0]       i_vel_x,
    input  logic signed [mwm_pkg::IN_W-1:0]       i_vel_y,
    input  logic signed [mwm_pkg::IN_W-1:0]       i_yaw_rate,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [mwm_pkg::OUT_W-1:0]      o_wheel0_pwm,
    output logic signed [mwm_pkg::OUT_W-1:0]      o_wheel1_pwm,
    output logic signed [mwm_pkg::OUT_W-1:0]      o_wheel2_pwm,
    output logic signed [mwm_pkg::OUT_W-1:0]      o_wheel3_pwm,
    output logic                                  o_scaled_down,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mwm_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int unsigned DIV_STEPS = mwm_pkg::QUO_W;

    mwm_pkg::t_cfg                       r_cfg;
    mwm_pkg::t_div_item                  stg_item  [DIV_STEPS+1];
    logic                                stg_valid [DIV_STEPS+1];
    logic                                stg_ready [DIV_STEPS+1];

    logic                                r_o_v;
    logic                                rdy_o;
    logic signed [mwm_pkg::OUT_W-1:0]    r_pwm [mwm_pkg::LANES];
    logic signed [mwm_pkg::OUT_W-1:0]    n_pwm [mwm_pkg::LANES];
    logic                                r_scaled;
    logic [mwm_pkg::QUO_W-1:0]           q;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lever_arm <= mwm_pkg::RST_LEVER_ARM;
            r_cfg.ref_speed <= mwm_pkg::RST_REF_SPEED;
            r_cfg.max_pwm   <= mwm_pkg::RST_MAX_PWM;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mwm_pkg::REG_LEVER_ARM: begin
                    r_cfg.lever_arm <= i_cfg_data[mwm_pkg::LEVER_W-1:0];
                end
                mwm_pkg::REG_REF_SPEED: begin
                    r_cfg.ref_speed <= i_cfg_data[mwm_pkg::REF_W-1:0];
                end
                mwm_pkg::REG_MAX_PWM: begin
                    r_cfg.max_pwm <= i_cfg_data[mwm_pkg::PWM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mwm_mix u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_vel_x    (i_vel_x),
        .i_vel_y    (i_vel_y),
        .i_yaw_rate (i_yaw_rate),
        .o_valid    (stg_valid[0]),
        .i_ready    (stg_ready[0]),
        .o_item     (stg_item[0])
    );

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        mwm_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .o_ready (stg_ready[k]),
            .i_item  (stg_item[k]),
            .o_valid (stg_valid[k+1]),
            .i_ready (stg_ready[k+1]),
            .o_item  (stg_item[k+1])
        );
    end

    assign rdy_o                = !r_o_v || i_ready;
    assign stg_ready[DIV_STEPS] = rdy_o;

    always_comb begin
        q = '0;
        for (int i = 0; i < mwm_pkg::LANES; i++) begin
            q = (stg_item[DIV_STEPS].lane[i].quo > r_cfg.max_pwm)
              ? r_cfg.max_pwm : stg_item[DIV_STEPS].lane[i].quo;
            n_pwm[i] = stg_item[DIV_STEPS].lane[i].neg
                     ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (rdy_o) begin
            r_o_v <= stg_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o && stg_valid[DIV_STEPS]) begin
            r_pwm    <= n_pwm;
            r_scaled <= stg_item[DIV_STEPS].reduced;
        end
    end

    assign o_valid       = r_o_v;
    assign o_wheel0_pwm  = r_pwm[0];
    assign o_wheel1_pwm  = r_pwm[1];
    assign o_wheel2_pwm  = r_pwm[2];
    assign o_wheel3_pwm  = r_pwm[3];
    assign o_scaled_down = r_scaled;

`ifndef SYNTHESIS
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled while pipeline has room");

    a_cfg_lever: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == mwm_pkg::REG_LEVER_ARM)
        |=> r_cfg.lever_arm == $past(i_cfg_data[mwm_pkg::LEVER_W-1:0]))
        else $error("lever arm write lost");

    a_cfg_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == mwm_pkg::REG_MAX_PWM)
        |=> r_cfg.max_pwm == $past(i_cfg_data[mwm_pkg::PWM_W-1:0]))
        else $error("max pwm write lost");
`endif

endmodule
